[rtl/pftd_pkg.sv]
// Shared constants and controller/datapath interface types for the trial-division factorizer.
// No dependencies. Every other file in rtl/ imports this package.
package pftd_pkg;

    // Default operand width and the limit on results per input
    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_RESULTS    = 30;
    localparam int CNT_BITS       = $clog2(MAX_RESULTS + 1);

    // Source of a factor staged into the pending slot
    typedef enum logic [1:0] {
        STG_TWO = 2'd0,
        STG_DIV = 2'd1,
        STG_REM = 2'd2
    } stage_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;       // take the input value
        logic       stage;      // put a factor in the pending slot
        stage_sel_t stage_sel;  // which factor is staged
        logic       init_div;   // trial divisor <= 3
        logic       step_div;   // trial divisor += 2
        logic       div_start;  // start remainder / divisor
        logic       flush;      // send the pending item as the last one
    } pftd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_small;   // input value is 0 or 1
        logic r_lsb;      // remainder is odd
        logic cnt_max;    // result limit reached
        logic can_stage;  // pending slot can take a factor this cycle
        logic out_free;   // output register can take an item this cycle
        logic div_done;   // divider result is valid
        logic div_over;   // divisor > quotient: search is over
        logic div_exact;  // divisor divides the remainder
        logic rem_gt2;    // remainder above 2
    } pftd_sts_t;

endpackage

[rtl/pftd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pftd_pkg; used by pftd_datapath.
module pftd_div
    import pftd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]   divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIV_BITS-1:0]   remainder
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quot_reg;
    logic [DIV_BITS-1:0]   prem_reg;
    logic [DIV_BITS-1:0]   dvsr_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  done_reg;

    logic [DIV_BITS:0] shifted;
    logic [DIV_BITS:0] diff;
    logic              fits;

    // Trial subtraction of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {prem_reg, quot_reg[VALUE_BITS-1]};
        diff    = shifted - {1'b0, dvsr_reg};
        fits    = shifted >= {1'b0, dvsr_reg};
    end

    // Control: bit counter and done flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(VALUE_BITS);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: quotient shifts in as the dividend shifts out
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            prem_reg <= '0;
            dvsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (fits) begin
                prem_reg <= diff[DIV_BITS-1:0];
                quot_reg <= {quot_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                prem_reg <= shifted[DIV_BITS-1:0];
                quot_reg <= {quot_reg[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = prem_reg;

endmodule

[rtl/pftd_datapath.sv]
// Datapath: remainder, trial divisor, pending factor slot and output register.
// Depends on pftd_pkg and pftd_div; driven by pftd_ctrl through pftd_cmd_t.
module pftd_datapath
    import pftd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_BITS-1:0] s_value,
    input  pftd_cmd_t             cmd,
    output pftd_sts_t             sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_factor,
    output logic                  m_last,
    output logic                  m_no_factors
);

    // Trial divisor never passes sqrt(2^VALUE_BITS) + 2
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

    logic [VALUE_BITS-1:0] rem_reg;
    logic [DIV_BITS-1:0]   div_reg;
    logic [VALUE_BITS-1:0] pend_factor_reg;
    logic                  pend_nof_reg;
    logic                  pend_vld_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_factor_reg;
    logic                  m_last_reg;
    logic                  m_nof_reg;

    logic                  dv_done;
    logic [VALUE_BITS-1:0] dv_quot;
    logic [DIV_BITS-1:0]   dv_rem;
    logic [VALUE_BITS-1:0] stage_val;
    logic                  out_free;
    logic                  push;

    pftd_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (rem_reg),
        .divisor   (div_reg),
        .done      (dv_done),
        .quotient  (dv_quot),
        .remainder (dv_rem)
    );

    // Factor being staged
    always_comb begin
        case (cmd.stage_sel)
            STG_TWO: stage_val = VALUE_BITS'(2);
            STG_DIV: stage_val = VALUE_BITS'(div_reg);
            STG_REM: stage_val = rem_reg;
            default: stage_val = rem_reg;
        endcase
    end

    // Pending item moves to the output on a new stage or at the end of the run
    assign out_free = !m_valid_reg || m_ready;
    assign push     = (cmd.stage && pend_vld_reg) || cmd.flush;

    // Status to the controller
    always_comb begin
        sts.in_small  = s_value < VALUE_BITS'(2);
        sts.r_lsb     = rem_reg[0];
        sts.cnt_max   = cnt_reg == CNT_BITS'(MAX_RESULTS);
        sts.can_stage = !pend_vld_reg || out_free;
        sts.out_free  = out_free;
        sts.div_done  = dv_done;
        sts.div_over  = VALUE_BITS'(div_reg) > dv_quot;
        sts.div_exact = dv_rem == '0;
        sts.rem_gt2   = rem_reg > VALUE_BITS'(2);
    end

    // Remainder and trial divisor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            div_reg <= '0;
        end else begin
            if (cmd.load) begin
                rem_reg <= s_value;
            end else if (cmd.stage) begin
                case (cmd.stage_sel)
                    STG_TWO: rem_reg <= rem_reg >> 1;
                    STG_DIV: rem_reg <= dv_quot;
                    default: rem_reg <= VALUE_BITS'(1);
                endcase
            end
            if (cmd.load) begin
                div_reg <= '0;
            end else if (cmd.init_div) begin
                div_reg <= DIV_BITS'(3);
            end else if (cmd.step_div) begin
                div_reg <= div_reg + DIV_BITS'(2);
            end
        end
    end

    // Pending slot and result count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (cmd.load) begin
            pend_vld_reg <= sts.in_small;
            cnt_reg      <= '0;
        end else if (cmd.stage) begin
            pend_vld_reg <= 1'b1;
            cnt_reg      <= cnt_reg + CNT_BITS'(1);
        end else if (cmd.flush) begin
            pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pend_factor_reg <= '0;
            pend_nof_reg    <= sts.in_small;
        end else if (cmd.stage) begin
            pend_factor_reg <= stage_val;
            pend_nof_reg    <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_factor_reg <= pend_factor_reg;
            m_last_reg   <= cmd.flush;
            m_nof_reg    <= pend_nof_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_factor     = m_factor_reg;
    assign m_last       = m_last_reg;
    assign m_no_factors = m_nof_reg;

    // A push never overwrites an item that is still waiting
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("pftd: push into occupied output register");

    // An empty-factor item always closes its run
    a_nof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_nof_reg) |-> m_last_reg)
        else $error("pftd: no_factors item without last");

    // Divider never started with a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (div_reg != '0))
        else $error("pftd: divide by zero");

    // Result count stays within the run limit
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_BITS'(MAX_RESULTS))
        else $error("pftd: result count overflow");

    // Flush only ever sends a real pending item
    a_flush_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> pend_vld_reg)
        else $error("pftd: flush with empty pending slot");

endmodule

[rtl/pftd_ctrl.sv]
// Controller state machine sequencing the trial-division search.
// Depends on pftd_pkg; drives pftd_datapath through pftd_cmd_t.
module pftd_ctrl
    import pftd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pftd_sts_t sts,
    output pftd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_DIV_START,
        S_DIV_WAIT,
        S_TAIL,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_small ? S_FLUSH : S_TWOS;
                end
            end
            // Divide out factors of two, one per cycle while the pending slot can take one
            S_TWOS: begin
                if (sts.cnt_max) begin
                    state_next = S_FLUSH;
                end else if (!sts.r_lsb) begin
                    if (sts.can_stage) begin
                        cmd.stage     = 1'b1;
                        cmd.stage_sel = STG_TWO;
                    end
                end else begin
                    cmd.init_div = 1'b1;
                    state_next   = S_DIV_START;
                end
            end
            S_DIV_START: begin
                if (sts.cnt_max) begin
                    state_next = S_FLUSH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                end
            end
            // Quotient below divisor means divisor squared exceeds remainder
            S_DIV_WAIT: begin
                if (sts.div_done) begin
                    if (sts.div_over) begin
                        state_next = S_TAIL;
                    end else if (sts.div_exact) begin
                        if (sts.can_stage) begin
                            cmd.stage     = 1'b1;
                            cmd.stage_sel = STG_DIV;
                            state_next    = S_DIV_START;
                        end
                    end else begin
                        cmd.step_div = 1'b1;
                        state_next   = S_DIV_START;
                    end
                end
            end
            // Leftover remainder above two is the largest prime
            S_TAIL: begin
                if (sts.rem_gt2 && !sts.cnt_max) begin
                    if (sts.can_stage) begin
                        cmd.stage     = 1'b1;
                        cmd.stage_sel = STG_REM;
                        state_next    = S_FLUSH;
                    end
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/prime_factor_trial_division.sv]
// Prime factorization by trial division: one value in, a run of prime factors out.
// Usage notes below. Depends on pftd_pkg, pftd_ctrl, pftd_datapath.
//
// Input channel s_valid/s_ready/s_value: one transfer per value. s_ready is high
// only while no value is in work; the next value is taken once the previous run
// has been handed to the output register.
// Output channel m_valid/m_ready: one transfer per factor, ascending, with
// repeats; m_last marks the final factor of the run. Values 0 and 1 give one
// transfer with factor 0, m_last and m_no_factors set.
// A value 0 or 1 goes from its transfer straight to the flush state. Factors of
// two are divided out by shifting; each odd trial divisor is tested by the
// bit-serial divider that computes remainder / divisor. Worst case is a prime
// near 2^31, which takes about 23170 trials.
// A run holds at most 30 factors; the run is cut there with m_last set.
// A stalled receiver stops the search when the next factor finds both the
// output register and the pending slot full; nothing is dropped.
// Reset (aresetn low, synchronous) abandons any run and clears m_valid.
module prime_factor_trial_division
    import pftd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_factor,
    output logic                  m_last,
    output logic                  m_no_factors
);

    pftd_cmd_t cmd;
    pftd_sts_t sts;

    pftd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pftd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_value      (s_value),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_factor     (m_factor),
        .m_last       (m_last),
        .m_no_factors (m_no_factors)
    );

endmodule

[dv/prime_factor_trial_division_tb.sv]
// Self-checking testbench for prime_factor_trial_division: factors each sent value in
// its own trial-division model and compares every factor transfer in order.
// Depends on rtl/pftd_pkg.sv and rtl/prime_factor_trial_division.sv.
module prime_factor_trial_division_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pftd_pkg::*;

    localparam int              VB          = VALUE_BITS_DEF;
    localparam longint unsigned MAX_VAL     = (64'd1 << VB) - 1;
    localparam longint          LIMIT_CYC   = 8_000_000;
    localparam int              SETTLE_CYC  = 4 * (VB + 2);
    localparam int              PRINT_LIMIT = 100;

    typedef struct {
        logic [VB-1:0] factor;
        logic          last;
        logic          no_factors;
    } factor_item_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_valid  = 1'b0;
    logic          s_ready;
    logic [VB-1:0] s_value  = '0;
    logic          m_valid;
    logic          m_ready  = 1'b0;
    logic [VB-1:0] m_factor;
    logic          m_last;
    logic          m_no_factors;

    factor_item_t pending_factors[$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    longint       cycle_count    = 0;
    int unsigned  prime_tab [0:15] = '{2, 3, 5, 7, 11, 13, 17, 19,
                                       23, 29, 31, 37, 41, 43, 47, 53};

    prime_factor_trial_division #(
        .VALUE_BITS(VB)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_factor    (m_factor),
        .m_last      (m_last),
        .m_no_factors(m_no_factors)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYC) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver backpressure, one decision per falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Trial division: twos first, then odd divisors while d*d <= remainder,
    // then whatever is left above 2. Runs are capped at MAX_RESULTS factors.
    function automatic void factorize(input logic [VB-1:0] value);
        longint unsigned rem;
        longint unsigned div;
        longint unsigned run[$];
        factor_item_t    item;
        rem = 64'(value);
        if (rem < 2) begin
            item.factor     = '0;
            item.last       = 1'b1;
            item.no_factors = 1'b1;
            pending_factors.push_back(item);
            return;
        end
        while (rem[0] == 1'b0 && run.size() < MAX_RESULTS) begin
            run.push_back(64'd2);
            rem = rem >> 1;
        end
        div = 64'd3;
        while (run.size() < MAX_RESULTS && div <= rem / div) begin
            if (rem % div == 0) begin
                run.push_back(div);
                rem = rem / div;
            end else begin
                div = div + 64'd2;
            end
        end
        if (rem > 2 && run.size() < MAX_RESULTS)
            run.push_back(rem);
        foreach (run[i]) begin
            item.factor     = run[i][VB-1:0];
            item.last       = (i == run.size() - 1);
            item.no_factors = 1'b0;
            pending_factors.push_back(item);
        end
    endfunction

    // Compare each output transfer with the oldest pending factor
    always @(posedge aclk) begin : check_results
        factor_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_factors.size() == 0) begin
                report_mismatch("factor with none pending", m_factor, 0);
            end else begin
                want = pending_factors.pop_front();
                if (m_factor !== want.factor)
                    report_mismatch("factor", m_factor, want.factor);
                if (m_last !== want.last)
                    report_mismatch("last", m_last, want.last);
                if (m_no_factors !== want.no_factors)
                    report_mismatch("no_factors", m_no_factors, want.no_factors);
            end
        end
    end

    // One input transfer; ends at the accepting rising edge
    task automatic send_value(input logic [VB-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        factorize(value);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Hold the sender idle until every pending factor has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_factors.size() != 0) @(posedge aclk);
    endtask

    // Mostly smooth numbers so the search stays short; some tiny and some
    // narrow raw values as noise.
    function automatic logic [VB-1:0] random_value();
        longint unsigned v;
        longint unsigned c;
        int              kind;
        int              w;
        kind = $urandom_range(9);
        if (kind < 7) begin
            v = 1;
            repeat ($urandom_range(10, 1)) begin
                c = prime_tab[$urandom_range(15)];
                if (v * c <= MAX_VAL) v = v * c;
            end
            if ($urandom_range(2) == 0) begin
                c = $urandom_range(65535, 2);
                if (v * c <= MAX_VAL) v = v * c;
            end
        end else if (kind == 7) begin
            v = $urandom_range(3);
        end else begin
            w = $urandom_range(20, 1);
            v = $urandom & ((64'd1 << w) - 1);
        end
        return v[VB-1:0];
    endfunction

    // Zero and one: single no-factor transfer
    task automatic test_no_factor_inputs();
        set_idling(0, 0);
        send_value(VB'(0));
        send_value(VB'(1));
        send_value(VB'(0));
    endtask

    task automatic test_small_values();
        set_idling(0, 0);
        send_value(VB'(2));
        send_value(VB'(3));
        send_value(VB'(4));
        send_value(VB'(6));
        send_value(VB'(97));
    endtask

    // Long runs under a slow receiver; 2^30 fills the run limit exactly
    task automatic test_long_runs();
        set_idling(0, 85);
        send_value(VB'(64'd1 << 30));
        send_value(VB'(1162261467));     // 3^19
        send_value(VB'(116396280));      // 2^3*3^2*5*7*11*13*17*19
        wait_drained();
    endtask

    // Divisor squared equal to, just under and far under the remainder
    task automatic test_square_bound();
        set_idling(0, 0);
        send_value(VB'(9));
        send_value(VB'(25));
        send_value(VB'(63001));          // 251^2
        send_value(VB'(64507));          // 251*257
        send_value(VB'(1299709));        // prime
    endtask

    // All ones is a prime and takes the full search
    task automatic test_bit_patterns();
        set_idling(0, 0);
        send_value(VB'(MAX_VAL));
        send_value(VB'(32'h5555_5555));
        send_value(VB'(32'h2AAA_AAAA));
        send_value(VB'(MAX_VAL - 1));
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        set_idling(src_pct, sink_pct);
        repeat (count) send_value(random_value());
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_no_factor_inputs();
        test_small_values();
        test_long_runs();
        test_square_bound();
        test_bit_patterns();
        wait_drained();

        test_random_traffic(25, 0, 0);
        test_random_traffic(25, 85, 0);
        test_random_traffic(25, 0, 85);
        test_random_traffic(25, 35, 35);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (pending_factors.size() != 0)
            report_mismatch("factors never produced", 0, pending_factors.size());

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
